// ===== design/fbba_pkg.sv =====
// fbba_pkg: shared constants, status codes, command and status structs and helper functions
// for the fixed block bitmap allocator; no dependencies
package fbba_pkg;

	localparam int ADDR_W          = 32;
	localparam int ST_W            = 3;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam int NUM_BLOCKS_DEF  = 64;
	localparam int GRP_W           = 8;
	localparam int GRP_BW          = $clog2(GRP_W);

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_NULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_MISALIGN = 3'd4,
		ST_DOUBLE   = 3'd5
	} fbba_status_t;

	typedef struct packed {
		logic         capture;
		logic         scan_inc;
		logic         rd_free;
		logic         alloc_wr;
		logic         free_wr;
		logic         addr_calc;
		logic         div_init;
		logic         div_step;
		logic         set_st;
		fbba_status_t st_code;
		logic         out_load;
	} fbba_cmd_t;

	typedef struct packed {
		logic op_free;
		logic is_null;
		logic out_of_range;
		logic any_free;
		logic blk_free;
		logic scan_last;
		logic misalign;
	} fbba_sts_t;

	// lowest set bit of a group word
	function automatic logic [GRP_BW-1:0] fbba_first(input logic [GRP_W-1:0] w);
		logic [GRP_BW-1:0] r;
		r = '0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (w[b]) begin
				r = GRP_BW'(b);
			end
		end
		return r;
	endfunction

	// blocks of group grp that exist in a pool of nb blocks
	function automatic logic [GRP_W-1:0] fbba_grp_mask(input int nb, input int grp);
		logic [GRP_W-1:0] m;
		m = '0;
		for (int b = 0; b < GRP_W; b++) begin
			m[b] = ((grp * GRP_W + b) < nb);
		end
		return m;
	endfunction

endpackage

// ===== design/fbba_intf.sv =====
// fbba_req_if and fbba_rsp_if: valid/ready channels of the bitmap allocator
// no dependencies
interface fbba_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink (input valid, input opcode, input address, output ready);
endinterface

interface fbba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_address;
	logic [2:0]  status;

	modport source (output valid, output block_address, output status, input ready);
	modport sink (input valid, input block_address, input status, output ready);
endinterface

// ===== design/fbba_ctrl.sv =====
// fbba_ctrl: request sequencer of the bitmap allocator, drives datapath commands
// depends on fbba_pkg
module fbba_ctrl import fbba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output fbba_cmd_t cmd,
	input  fbba_sts_t sts
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ARD  = 9'b000000010,
		S_ACHK = 9'b000000100,
		S_AMUL = 9'b000001000,
		S_FCHK = 9'b000010000,
		S_FDIV = 9'b000100000,
		S_FRD  = 9'b001000000,
		S_FWB  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = sts.op_free ? S_FCHK : S_ARD;
				end
			end
			S_ARD: begin
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (sts.any_free) begin
					cmd.alloc_wr = 1'b1;
					state_d      = S_AMUL;
				end else if (sts.scan_last) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_FULL;
					state_d     = S_OUT;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = S_ARD;
				end
			end
			S_AMUL: begin
				cmd.addr_calc = 1'b1;
				cmd.set_st    = 1'b1;
				cmd.st_code   = ST_OK;
				state_d       = S_OUT;
			end
			S_FCHK: begin
				if (sts.is_null) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_NULL;
					state_d     = S_OUT;
				end else if (sts.out_of_range) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_RANGE;
					state_d     = S_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_FDIV;
				end
			end
			S_FDIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_FRD;
			end
			S_FRD: begin
				cmd.rd_free = 1'b1;
				if (sts.misalign) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_MISALIGN;
					state_d     = S_OUT;
				end else begin
					state_d = S_FWB;
				end
			end
			S_FWB: begin
				cmd.rd_free = 1'b1;
				cmd.set_st  = 1'b1;
				if (sts.blk_free) begin
					cmd.st_code = ST_DOUBLE;
				end else begin
					cmd.free_wr = 1'b1;
					cmd.st_code = ST_OK;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_ARD || state_q == S_FCHK)
		else $error("accepted transaction did not start work");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> rsp_valid && state_q == S_IDLE)
		else $error("result not presented after completion");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req_ready)
		else $error("ready while a transaction is in progress");

endmodule

// ===== design/fbba_dp.sv =====
// fbba_dp: free bitmap memory, first-free search, address checks, index divider and result
// registers of the bitmap allocator; depends on fbba_pkg
module fbba_dp import fbba_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbba_cmd_t          cmd,
	output fbba_sts_t          sts,
	input  logic               cfg_we,
	input  logic [ADDR_W-1:0]  cfg_wdata,
	input  logic               in_opcode,
	input  logic [ADDR_W-1:0]  in_address,
	output logic [ADDR_W-1:0]  out_block_address,
	output logic [ST_W-1:0]    out_status
);

	localparam int NG  = (NUM_BLOCKS + GRP_W - 1) / GRP_W;
	localparam int NGW = (NG > 1) ? $clog2(NG) : 1;
	localparam int IW  = NGW + GRP_BW;
	localparam int LB  = $clog2(BLOCK_BYTES);
	localparam int DW  = LB + IW;
	localparam int RSH = DW + LB;
	localparam int PW  = 2 * DW + 1;
	localparam longint RECIP = ((longint'(1) << RSH) + longint'(BLOCK_BYTES) - 1) /
		longint'(BLOCK_BYTES);
	localparam logic [ADDR_W:0]   SPAN     = (ADDR_W + 1)'(NUM_BLOCKS * BLOCK_BYTES);
	localparam logic [PW-1:0]     RECIP_P  = PW'(RECIP);
	localparam logic [RSH:0]      RECIP_C  = (RSH + 1)'(RECIP);
	localparam logic [NGW-1:0]    LAST_GRP = NGW'(NG - 1);

	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] addr_q;
	logic [NGW-1:0]    scan_q;
	logic [IW-1:0]     idx_q;
	logic [PW-1:0]     prod_q;
	logic [IW-1:0]     quo_q;
	logic              mis_q;
	logic [GRP_W-1:0]  mem [NG];
	logic [NG-1:0]     vld_q;
	logic [GRP_W-1:0]  rdata_q;
	logic              rvld_q;
	logic [ADDR_W-1:0] res_addr_q;
	fbba_status_t      res_st_q;
	logic [ADDR_W-1:0] out_addr_q;
	fbba_status_t      out_st_q;

	logic [ADDR_W-1:0] offset;
	logic [GRP_W-1:0]  word;
	logic [GRP_W-1:0]  avail;
	logic [GRP_BW-1:0] enc;
	logic [NGW-1:0]    qgrp;
	logic [GRP_BW-1:0] qbit;
	logic [NGW-1:0]    raddr;
	logic [NGW-1:0]    waddr;
	logic [GRP_W-1:0]  wdata;
	logic              wen;

	assign offset = addr_q - base_q;
	assign word   = rvld_q ? rdata_q : '1;
	assign avail  = word & fbba_grp_mask(NUM_BLOCKS, int'(scan_q));
	assign enc    = fbba_first(avail);
	assign qgrp   = quo_q[IW-1:GRP_BW];
	assign qbit   = quo_q[GRP_BW-1:0];
	assign raddr  = cmd.rd_free ? qgrp : scan_q;
	assign wen    = cmd.alloc_wr || cmd.free_wr;

	always_comb begin
		if (cmd.alloc_wr) begin
			waddr = scan_q;
			wdata = word & ~(GRP_W'(1) << enc);
		end else begin
			waddr = qgrp;
			wdata = word | (GRP_W'(1) << qbit);
		end
	end

	always_comb begin
		sts.op_free      = in_opcode;
		sts.is_null      = (addr_q == '0);
		sts.out_of_range = (addr_q < base_q) || ({1'b0, offset} >= SPAN);
		sts.any_free     = |avail;
		sts.blk_free     = word[qbit];
		sts.scan_last    = (scan_q == LAST_GRP);
		sts.misalign     = mis_q;
	end

	// bitmap storage, group valid bits stand for the all-free reset value
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			base_q <= '0;
		end else begin
			if (wen) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q     <= in_address;
			scan_q     <= '0;
			res_addr_q <= '0;
		end
		if (cmd.scan_inc) begin
			scan_q <= scan_q + NGW'(1);
		end
		if (cmd.alloc_wr) begin
			idx_q <= {scan_q, enc};
		end
		if (cmd.addr_calc) begin
			res_addr_q <= base_q + ADDR_W'(idx_q) * ADDR_W'(BLOCK_BYTES);
		end
		if (cmd.set_st) begin
			res_st_q <= cmd.st_code;
		end
		// block index and alignment of the offset by reciprocal multiplication
		if (cmd.div_init) begin
			prod_q <= PW'(offset[DW-1:0]) * RECIP_P;
		end
		if (cmd.div_step) begin
			quo_q <= prod_q[RSH +: IW];
			mis_q <= ({1'b0, prod_q[RSH-1:0]} >= RECIP_C);
		end
		if (cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	assign out_block_address = out_addr_q;
	assign out_status        = out_st_q;

	a_wr_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.alloc_wr && cmd.free_wr))
		else $error("allocate and free write in the same cycle");

	a_alloc_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |=> !vld_q[scan_q] == 1'b0)
		else $error("allocated group not marked written");

	a_free_checked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_wr |-> !sts.blk_free && !sts.misalign && !sts.out_of_range)
		else $error("free written without passing the checks");

endmodule

// ===== design/fixed_block_bitmap_allocator_top.sv =====
// Fixed block bitmap allocator, first fit. One transaction in work at a time.
// Allocate: groups of 8 blocks are scanned in order, one bitmap group read per pass through the
// read and check states, then the block address is computed; pool full after the last group. Free:
// null and range check, index division, bitmap read and alignment check, double-free check and write
// back. Next request taken in the cycle the result is presented; a result still waiting holds the
// block in its last state. Reset: every block free at once through per-group valid bits, base 0.
module fixed_block_bitmap_allocator_top import fbba_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fbba_req_if.sink          req,
	fbba_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	fbba_cmd_t cmd;
	fbba_sts_t sts;

	fbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fbba_dp #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.NUM_BLOCKS  (NUM_BLOCKS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_opcode         (req.opcode),
		.in_address        (req.address),
		.out_block_address (rsp.block_address),
		.out_status        (rsp.status)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for fixed_block_bitmap_allocator_top; a free-bitmap
// predictor checks every response; depends on fbba_pkg, fbba_req_if and fbba_rsp_if
module tb;
	import fbba_pkg::*;

	localparam int BLK = BLOCK_BYTES_DEF;
	localparam int NBLK = NUM_BLOCKS_DEF;
	localparam longint POOL_SPAN = longint'(NBLK) * BLK;
	localparam int QUIET_CYCLES = 30;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef struct {
		logic [31:0]  block_address;
		fbba_status_t status;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	fbba_req_if req();
	fbba_rsp_if rsp();

	fixed_block_bitmap_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [31:0] base_model;
	bit          blk_free_model [NBLK];
	grant_t      grants_due [$];
	grant_t      oldest;
	int          errors;
	int          rsp_hold;
	int          stall_left;
	bit          burst_mode;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("FAIL fixed_block_bitmap_allocator_top");
		$finish;
	end

	function automatic grant_t calc_grant(input logic op, input logic [31:0] a);
		grant_t g;
		int     idx;
		longint off;
		g.block_address = '0;
		g.status = ST_OK;
		if (op == OP_ALLOC) begin
			idx = -1;
			for (int i = NBLK - 1; i >= 0; i--) begin
				if (blk_free_model[i]) begin
					idx = i;
				end
			end
			if (idx < 0) begin
				g.status = ST_FULL;
			end else begin
				blk_free_model[idx] = 1'b0;
				g.block_address = 32'(longint'(base_model) + longint'(idx) * BLK);
			end
		end else if (a == '0) begin
			g.status = ST_NULL;
		end else begin
			off = longint'(a) - longint'(base_model);
			if (off < 0 || off >= POOL_SPAN) begin
				g.status = ST_RANGE;
			end else if (off % BLK != 0) begin
				g.status = ST_MISALIGN;
			end else if (blk_free_model[off / BLK]) begin
				g.status = ST_DOUBLE;
			end else begin
				blk_free_model[off / BLK] = 1'b1;
			end
		end
		return g;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] block_addr(input int idx);
		return 32'(longint'(base_model) + longint'(idx) * BLK);
	endfunction

	function automatic logic [31:0] pick_free_address();
		int r;
		int idx;
		r = $urandom_range(0, 99);
		idx = $urandom_range(0, NBLK - 1);
		for (int k = 0; k < NBLK; k++) begin
			if (blk_free_model[idx]) begin
				idx = (idx + 1) % NBLK;
			end
		end
		if (r < 55) begin
			return block_addr(idx);
		end else if (r < 70) begin
			return 32'(longint'(base_model) + $urandom_range(0, POOL_SPAN + 256) - 128);
		end else if (r < 78) begin
			return block_addr(idx) + $urandom_range(1, BLK - 1);
		end else if (r < 88) begin
			return '0;
		end
		return $urandom();
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got 0x%08h want 0x%08h", $time, what, got, want);
		errors++;
	endtask

	// response side: random stalls plus a forced hold-off
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp.ready <= 1'b0;
			rsp_hold--;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
			rsp.ready <= 1'b0;
			stall_left = pick_gap();
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (grants_due.size() == 0) begin
				report_mismatch("unexpected transaction", rsp.block_address, '0);
			end else begin
				oldest = grants_due.pop_front();
				if (rsp.block_address !== oldest.block_address) begin
					report_mismatch("block_address", rsp.block_address, oldest.block_address);
				end
				if (rsp.status !== oldest.status) begin
					report_mismatch("status", 32'(rsp.status), 32'(oldest.status));
				end
			end
		end
	end

	task automatic send(input logic op, input logic [31:0] a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.address <= a;
		do @(posedge clk); while (!req.ready);
		grants_due.push_back(calc_grant(op, a));
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_pool_base(input logic [31:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_model = v;
	endtask

	task automatic test_directed();
		send(OP_FREE, 32'h0);
		send(OP_ALLOC, 32'hFFFF_FFFF);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		send(OP_FREE, 32'h40);
		send(OP_FREE, 32'h40);
		send(OP_FREE, 32'h41);
		send(OP_FREE, 32'h7F);
		send(OP_FREE, 32'h1000);
		send(OP_FREE, 32'hFC0);
		send(OP_FREE, 32'hFFFF_FFFF);
		send(OP_FREE, 32'h8000_0000);
		write_pool_base(32'h0000_1000);
		send(OP_ALLOC, 32'h5555_5555);
		send(OP_FREE, 32'h0000_0FFF);
		send(OP_FREE, 32'h0000_1000);
		send(OP_FREE, 32'h0000_1000);
		send(OP_FREE, 32'h0000_2000);
		send(OP_FREE, 32'h0000_1FC0);
		send(OP_ALLOC, 32'hAAAA_AAAA);
		write_pool_base(32'hFFFF_FFC0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'hFFFF_FFC0);
		send(OP_FREE, 32'hFFFF_FFFF);
	endtask

	// fill the pool past full, then release every block in shuffled order
	task automatic test_fill_drain();
		int order [NBLK];
		int j;
		int t;
		write_pool_base(32'h4000_0000);
		for (int i = 0; i < NBLK + 2; i++) begin
			send(OP_ALLOC, $urandom());
		end
		for (int i = 0; i < NBLK; i++) begin
			order[i] = i;
		end
		for (int i = NBLK - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < NBLK; i++) begin
			burst_mode = (i >= NBLK / 2);
			send(OP_FREE, block_addr(order[i]));
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_random_traffic(input logic [31:0] base, input int n);
		int  alloc_pct;
		logic op;
		write_pool_base(base);
		for (int k = 0; k < n; k++) begin
			if (k % 50 == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
			end
			alloc_pct = (k < n / 2) ? 65 : 35;
			op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			send(op, (op == OP_ALLOC) ? 32'($urandom()) : pick_free_address());
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_backpressure();
		burst_mode = 1'b1;
		rsp_hold = 150;
		for (int k = 0; k < 12; k++) begin
			send(k[0] ? OP_FREE : OP_ALLOC, k[0] ? pick_free_address() : 32'($urandom()));
		end
		burst_mode = 1'b0;
		wait_drained();
		for (int k = 0; k < 12; k++) begin
			send(k[1] ? OP_FREE : OP_ALLOC, pick_free_address());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.opcode = OP_ALLOC;
		req.address = '0;
		rsp.ready = 1'b0;
		errors = 0;
		rsp_hold = 0;
		stall_left = 0;
		burst_mode = 1'b0;
		base_model = '0;
		foreach (blk_free_model[i]) begin
			blk_free_model[i] = 1'b1;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain();
		test_random_traffic(32'h0000_0000, 220);
		test_random_traffic(32'h1234_5678, 220);
		test_random_traffic(32'hFFFF_F800, 220);
		test_random_traffic(32'hFFFF_FFFF, 220);
		test_random_traffic(32'h8000_0000, 220);
		test_random_traffic(32'h0000_0040, 220);
		test_backpressure();

		wait_drained();
		if (errors == 0) begin
			$display("PASS fixed_block_bitmap_allocator_top");
		end else begin
			$display("FAIL fixed_block_bitmap_allocator_top");
		end
		$finish;
	end

endmodule
